// ===== src/rpd_pkg.sv =====
package rpd_pkg;

    localparam int ERROR_WIDTH = 32;
    localparam int DUTY_MAX    = 255;

    localparam int SPEED_W   = 16;
    localparam int DELTA_W   = 12;
    localparam int STEP_W    = 16;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int FRAC_W    = 8;

    localparam int MEAS_W = DELTA_W + 1;
    localparam int ACC_W  = ERROR_WIDTH + 2;
    localparam int DIFF_W = ERROR_WIDTH + 1;
    localparam int PROD_W = DIFF_W + STEP_W + 2;
    localparam int TERM_W = PROD_W - 2 * FRAC_W;
    localparam int DRV_W  = TERM_W + 1;

    localparam logic [CFG_W-1:0] RST_ACCEL_X = CFG_W'(190);
    localparam logic [CFG_W-1:0] RST_DECEL_X = CFG_W'(345);
    localparam logic [CFG_W-1:0] RST_ACCEL_W = CFG_W'(384);
    localparam logic [CFG_W-1:0] RST_DECEL_W = CFG_W'(384);
    localparam logic [CFG_W-1:0] RST_KP_X    = CFG_W'(102);
    localparam logic [CFG_W-1:0] RST_KD_X    = CFG_W'(26);
    localparam logic [CFG_W-1:0] RST_KP_W    = CFG_W'(256);
    localparam logic [CFG_W-1:0] RST_KD_W    = CFG_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_X,
        REG_DECEL_X,
        REG_ACCEL_W,
        REG_DECEL_W,
        REG_KP_X,
        REG_KD_X,
        REG_KP_W,
        REG_KD_W
    } t_cfg_idx;

    typedef struct packed {
        logic [STEP_W-1:0] accel_x;
        logic [STEP_W-1:0] decel_x;
        logic [STEP_W-1:0] accel_w;
        logic [STEP_W-1:0] decel_w;
        logic [STEP_W-1:0] kp_x;
        logic [STEP_W-1:0] kd_x;
        logic [STEP_W-1:0] kp_w;
        logic [STEP_W-1:0] kd_w;
    } t_cfg;

    typedef struct packed {
        logic signed [ERROR_WIDTH-1:0] e_x;
        logic signed [DIFF_W-1:0]      b_x;
        logic signed [ERROR_WIDTH-1:0] e_w;
        logic signed [DIFF_W-1:0]      b_w;
    } t_err;

    typedef struct packed {
        logic signed [PROD_W-1:0] pk_x;
        logic signed [PROD_W-1:0] pd_x;
        logic signed [PROD_W-1:0] pk_w;
        logic signed [PROD_W-1:0] pd_w;
    } t_prod;

    typedef struct packed {
        logic signed [TERM_W-1:0] px;
        logic signed [TERM_W-1:0] pw;
    } t_term;

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
    } t_duty;

    // step toward target without passing it
    function automatic logic signed [SPEED_W-1:0] ramp(
        input logic signed [SPEED_W-1:0] cur,
        input logic signed [SPEED_W-1:0] tgt,
        input logic [STEP_W-1:0]         up,
        input logic [STEP_W-1:0]         down
    );
        logic signed [SPEED_W+1:0] cur_e;
        logic signed [SPEED_W+1:0] tgt_e;
        logic signed [SPEED_W+1:0] up_s;
        logic signed [SPEED_W+1:0] dn_s;
        logic signed [SPEED_W+1:0] up_v;
        logic signed [SPEED_W+1:0] dn_v;
        logic signed [SPEED_W-1:0] res;
        cur_e = (SPEED_W+2)'(cur);
        tgt_e = (SPEED_W+2)'(tgt);
        up_s  = {2'b00, up};
        dn_s  = {2'b00, down};
        up_v  = cur_e + up_s;
        dn_v  = cur_e - dn_s;
        if (cur < tgt) begin
            res = (up_v > tgt_e) ? tgt : up_v[SPEED_W-1:0];
        end else if (cur > tgt) begin
            res = (dn_v < tgt_e) ? tgt : dn_v[SPEED_W-1:0];
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // saturating error accumulation, measured counts scaled to q13.8
    function automatic logic signed [ERROR_WIDTH-1:0] err_update(
        input logic signed [ERROR_WIDTH-1:0] acc,
        input logic signed [SPEED_W-1:0]     speed,
        input logic signed [MEAS_W-1:0]      meas
    );
        logic signed [MEAS_W+FRAC_W-1:0] meas_q;
        logic signed [ACC_W-1:0]         sum;
        logic signed [ERROR_WIDTH-1:0]   res;
        meas_q = {meas, {FRAC_W{1'b0}}};
        sum    = ACC_W'(acc) + ACC_W'(speed) - ACC_W'(meas_q);
        if (sum[ACC_W-1:ERROR_WIDTH-1] == '0 || sum[ACC_W-1:ERROR_WIDTH-1] == '1) begin
            res = sum[ERROR_WIDTH-1:0];
        end else if (sum[ACC_W-1]) begin
            res = {1'b1, {(ERROR_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // divide by 2^16, rounding toward zero
    function automatic logic signed [TERM_W-1:0] trunc_q16(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [TERM_W-1:0] q;
        q = x[PROD_W-1:2*FRAC_W];
        if (x[PROD_W-1] && (x[2*FRAC_W-1:0] != '0)) begin
            q = q + TERM_W'(1);
        end
        return q;
    endfunction

    function automatic t_duty split(input logic signed [DRV_W-1:0] drive);
        logic signed [DRV_W-1:0] lim;
        logic signed [DRV_W-1:0] c;
        logic signed [DRV_W-1:0] neg;
        t_duty d;
        lim = DRV_W'(DUTY_MAX);
        if (drive > lim) begin
            c = lim;
        end else if (drive < -lim) begin
            c = -lim;
        end else begin
            c = drive;
        end
        neg = -c;
        if (c >= 0) begin
            d.fwd = c[DUTY_W-1:0];
            d.rev = '0;
        end else begin
            d.fwd = '0;
            d.rev = neg[DUTY_W-1:0];
        end
        return d;
    endfunction

endpackage

// ===== src/rpd_in_if.sv =====
interface rpd_in_if import rpd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] target_fwd_speed;
    logic signed [SPEED_W-1:0] target_rot_speed;
    logic signed [DELTA_W-1:0] left_delta;
    logic signed [DELTA_W-1:0] right_delta;

    modport source (
        output valid, target_fwd_speed, target_rot_speed, left_delta, right_delta,
        input  ready
    );
    modport sink (
        input  valid, target_fwd_speed, target_rot_speed, left_delta, right_delta,
        output ready
    );
endinterface

// ===== src/rpd_out_if.sv =====
interface rpd_out_if import rpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_fwd_duty;
    logic [DUTY_W-1:0] left_rev_duty;
    logic [DUTY_W-1:0] right_fwd_duty;
    logic [DUTY_W-1:0] right_rev_duty;

    modport source (
        output valid, left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
        input  ready
    );
    modport sink (
        input  valid, left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
        output ready
    );
endinterface

// ===== src/ramped_pd_differential_motor_control_top.sv =====
// channel   direction  handshake       payload
// i_in      sink       valid / ready   target_fwd_speed, target_rot_speed, left_delta,
//                                      right_delta
// o_out     source     valid / ready   left_fwd_duty, left_rev_duty, right_fwd_duty,
//                                      right_rev_duty
// cfg       write      i_cfg_we        i_cfg_idx, i_cfg_data
//
// one transaction per cycle sustained while the output is not stalled; the result is registered
// through four registers (ramp/error, multiplier, pd term, output)
// the ramp and error accumulation update is a combinational loop through its own registers, which sets the rate
// synchronous active-low reset clears speeds, error accumulators and valids, and loads config defaults
// a stalled output holds its transaction; the pipeline keeps filling until all stages are full
module ramped_pd_differential_motor_control_top import rpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpd_in_if.sink               i_in,
    rpd_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    t_err  w_err;
    t_term w_term;
    logic  w_err_valid;
    logic  w_err_ready;
    logic  w_term_valid;
    logic  w_term_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_x <= RST_ACCEL_X;
            r_cfg.decel_x <= RST_DECEL_X;
            r_cfg.accel_w <= RST_ACCEL_W;
            r_cfg.decel_w <= RST_DECEL_W;
            r_cfg.kp_x    <= RST_KP_X;
            r_cfg.kd_x    <= RST_KD_X;
            r_cfg.kp_w    <= RST_KP_W;
            r_cfg.kd_w    <= RST_KD_W;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_ACCEL_X: r_cfg.accel_x <= i_cfg_data;
                REG_DECEL_X: r_cfg.decel_x <= i_cfg_data;
                REG_ACCEL_W: r_cfg.accel_w <= i_cfg_data;
                REG_DECEL_W: r_cfg.decel_w <= i_cfg_data;
                REG_KP_X:    r_cfg.kp_x    <= i_cfg_data;
                REG_KD_X:    r_cfg.kd_x    <= i_cfg_data;
                REG_KP_W:    r_cfg.kp_w    <= i_cfg_data;
                REG_KD_W:    r_cfg.kd_w    <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    rpd_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (w_err_valid),
        .i_ready (w_err_ready),
        .o_err   (w_err)
    );

    rpd_pd u_pd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_err_valid),
        .o_ready (w_err_ready),
        .i_err   (w_err),
        .o_valid (w_term_valid),
        .i_ready (w_term_ready),
        .o_term  (w_term)
    );

    rpd_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_term_valid),
        .o_ready (w_term_ready),
        .i_term  (w_term),
        .o_out   (o_out)
    );

endmodule

// ===== src/rpd_track.sv =====
module rpd_track import rpd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    rpd_in_if.sink i_in,
    output logic   o_valid,
    input  logic   i_ready,
    output t_err   o_err
);

    logic                          r_valid;
    logic signed [SPEED_W-1:0]     r_cur_fwd;
    logic signed [SPEED_W-1:0]     r_cur_rot;
    logic signed [ERROR_WIDTH-1:0] r_fwd_acc;
    logic signed [ERROR_WIDTH-1:0] r_rot_acc;
    t_err                          r_err;

    logic signed [SPEED_W-1:0]     n_cur_fwd;
    logic signed [SPEED_W-1:0]     n_cur_rot;
    logic signed [ERROR_WIDTH-1:0] n_fwd_acc;
    logic signed [ERROR_WIDTH-1:0] n_rot_acc;
    t_err                          n_err;

    logic                     w_ready;
    logic                     w_accept;
    logic signed [MEAS_W-1:0] w_meas_fwd;
    logic signed [MEAS_W-1:0] w_meas_rot;

    assign w_ready    = !r_valid || i_ready;
    assign w_accept   = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    assign w_meas_fwd = MEAS_W'(i_in.right_delta) + MEAS_W'(i_in.left_delta);
    assign w_meas_rot = MEAS_W'(i_in.right_delta) - MEAS_W'(i_in.left_delta);

    always_comb begin
        n_cur_fwd = ramp(r_cur_fwd, i_in.target_fwd_speed, i_cfg.accel_x, i_cfg.decel_x);
        n_cur_rot = ramp(r_cur_rot, i_in.target_rot_speed, i_cfg.accel_w, i_cfg.decel_w);
        n_fwd_acc = err_update(r_fwd_acc, n_cur_fwd, w_meas_fwd);
        n_rot_acc = err_update(r_rot_acc, n_cur_rot, w_meas_rot);
        n_err.e_x = n_fwd_acc;
        n_err.b_x = DIFF_W'(r_fwd_acc) - DIFF_W'(n_fwd_acc);
        n_err.e_w = n_rot_acc;
        n_err.b_w = DIFF_W'(n_rot_acc) - DIFF_W'(r_rot_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cur_fwd <= '0;
            r_cur_rot <= '0;
            r_fwd_acc <= '0;
            r_rot_acc <= '0;
        end else begin
            if (w_accept) begin
                r_valid   <= 1'b1;
                r_cur_fwd <= n_cur_fwd;
                r_cur_rot <= n_cur_rot;
                r_fwd_acc <= n_fwd_acc;
                r_rot_acc <= n_rot_acc;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;

endmodule

// ===== src/rpd_pd.sv =====
module rpd_pd import rpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_err  i_err,
    output logic  o_valid,
    input  logic  i_ready,
    output t_term o_term
);

    logic  r_prod_valid;
    logic  r_term_valid;
    t_prod r_prod;
    t_term r_term;
    t_prod n_prod;
    t_term n_term;

    logic signed [STEP_W:0] w_kp_x;
    logic signed [STEP_W:0] w_kd_x;
    logic signed [STEP_W:0] w_kp_w;
    logic signed [STEP_W:0] w_kd_w;
    logic                   w_term_ready;
    logic                   w_prod_ready;

    assign w_kp_x = {1'b0, i_cfg.kp_x};
    assign w_kd_x = {1'b0, i_cfg.kd_x};
    assign w_kp_w = {1'b0, i_cfg.kp_w};
    assign w_kd_w = {1'b0, i_cfg.kd_w};

    assign w_term_ready = !r_term_valid || i_ready;
    assign w_prod_ready = !r_prod_valid || w_term_ready;
    assign o_ready      = w_prod_ready;

    always_comb begin
        n_prod.pk_x = w_kp_x * i_err.e_x;
        n_prod.pd_x = w_kd_x * i_err.b_x;
        n_prod.pk_w = w_kp_w * i_err.e_w;
        n_prod.pd_w = w_kd_w * i_err.b_w;
        n_term.px   = trunc_q16(r_prod.pk_x + r_prod.pd_x);
        n_term.pw   = trunc_q16(r_prod.pk_w + r_prod.pd_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_term_valid <= 1'b0;
        end else begin
            if (w_prod_ready) begin
                r_prod_valid <= i_valid;
            end
            if (w_term_ready) begin
                r_term_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prod_ready && i_valid) begin
            r_prod <= n_prod;
        end
        if (w_term_ready && r_prod_valid) begin
            r_term <= n_term;
        end
    end

    assign o_valid = r_term_valid;
    assign o_term  = r_term;

endmodule

// ===== src/rpd_drive.sv =====
module rpd_drive import rpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_term      i_term,
    rpd_out_if.source  o_out
);

    logic  r_valid;
    t_duty r_left;
    t_duty r_right;
    t_duty n_left;
    t_duty n_right;
    logic  w_ready;

    assign w_ready = !r_valid || o_out.ready;
    assign o_ready = w_ready;

    always_comb begin
        n_left  = split(DRV_W'(i_term.px) - DRV_W'(i_term.pw));
        n_right = split(DRV_W'(i_term.px) + DRV_W'(i_term.pw));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.left_fwd_duty  = r_left.fwd;
    assign o_out.left_rev_duty  = r_left.rev;
    assign o_out.right_fwd_duty = r_right.fwd;
    assign o_out.right_rev_duty = r_right.rev;

endmodule

// ===== src/rpd_checker.sv =====
module rpd_checker import rpd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_left_fwd_duty,
    input logic [DUTY_W-1:0] i_left_rev_duty,
    input logic [DUTY_W-1:0] i_right_fwd_duty,
    input logic [DUTY_W-1:0] i_right_rev_duty
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a side never drives forward and reverse at once
    a_left_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left_fwd_duty == '0 || i_left_rev_duty == '0))
        else $error("left forward and reverse both nonzero");

    a_right_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_right_fwd_duty == '0 || i_right_rev_duty == '0))
        else $error("right forward and reverse both nonzero");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_left_fwd_duty) && $stable(i_left_rev_duty)
            && $stable(i_right_fwd_duty) && $stable(i_right_rev_duty))
        else $error("output payload changed while stalled");

endmodule

bind ramped_pd_differential_motor_control_top rpd_checker u_rpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_left_fwd_duty  (o_out.left_fwd_duty),
    .i_left_rev_duty  (o_out.left_rev_duty),
    .i_right_fwd_duty (o_out.right_fwd_duty),
    .i_right_rev_duty (o_out.right_rev_duty)
);
